@@ rtl/core/waveform_oscillator_mixer_defines.svh @@
// Assertion macros for the oscillator mixer checker.
// Both macros sample on the rising clock edge and stay quiet while reset is low.
`ifndef WAVEFORM_OSCILLATOR_MIXER_DEFINES_SVH
`define WAVEFORM_OSCILLATOR_MIXER_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent.
`define WOM_ASSERT_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("oscillator mixer check failed");

// Check the consequent in the cycle after the antecedent.
`define WOM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("oscillator mixer check failed");

`endif

@@ rtl/core/wom_pkg.sv @@
// ----------------------------------------------------------------------------
// wom_pkg
// Shared types and constants of the oscillator mixer: sample types, register
// indexes, waveform codes and the structs passed between the modules.
// ----------------------------------------------------------------------------
package wom_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned TAB_W     = 15;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
  typedef logic [CFG_DAT_W-1:0]       cfg_dat_t;

  // Register indexes on the configuration channel
  localparam cfg_idx_t CFG_WAVE_SELECT = 3'd0;
  localparam cfg_idx_t CFG_OSC_ENABLE  = 3'd1;
  localparam cfg_idx_t CFG_FREQ_WORD   = 3'd2;
  localparam cfg_idx_t CFG_OFFSET_WORD = 3'd3;
  localparam cfg_idx_t CFG_AMPLITUDE   = 3'd4;

  localparam logic [TAB_W-1:0] AMPLITUDE_RESET = 15'd16384;

  typedef enum logic [1:0] {
    WAVE_COSINE = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_SAW    = 2'd2,
    WAVE_SILENT = 2'd3
  } wave_e;

  // Current register contents
  typedef struct packed {
    wave_e              wave_select;
    logic               osc_enable;
    logic [31:0]        freq_word;
    logic signed [31:0] offset_word;
    logic [TAB_W-1:0]   amplitude;
  } cfg_t;

  // Frame and phase snapshot held in the input stage
  typedef struct packed {
    logic [1:0]          quad;
    logic [SAMPLE_W-1:0] saw;
    sample_t             left;
    sample_t             right;
    logic                eob;
  } stage_t;

endpackage

@@ rtl/core/wom_if.sv @@
// ----------------------------------------------------------------------------
// wom_if
// Valid/ready channels of the oscillator mixer: input frames, output frames
// and configuration writes.
// ----------------------------------------------------------------------------
interface wom_in_if;
  logic              valid;
  logic              ready;
  wom_pkg::sample_t  left_in;
  wom_pkg::sample_t  right_in;
  logic              end_of_buffer;

  modport source (output valid, left_in, right_in, end_of_buffer, input ready);
  modport sink   (input valid, left_in, right_in, end_of_buffer, output ready);
endinterface

interface wom_out_if;
  logic              valid;
  logic              ready;
  wom_pkg::sample_t  left_out;
  wom_pkg::sample_t  right_out;
  logic              end_of_buffer_out;

  modport source (output valid, left_out, right_out, end_of_buffer_out, input ready);
  modport sink   (input valid, left_out, right_out, end_of_buffer_out, output ready);
endinterface

interface wom_cfg_if;
  logic              valid;
  logic              ready;
  wom_pkg::cfg_idx_t index;
  wom_pkg::cfg_dat_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/wom_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// wom_cfg_regs
// Configuration register file; takes one write word per cycle.
// ----------------------------------------------------------------------------
module wom_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  wom_cfg_if.sink       cfg_i,
  output wom_pkg::cfg_t cfg_o
);
  import wom_pkg::*;

  cfg_t regs_q;

  // Always take the write word
  assign cfg_i.ready = 1'b1;

  // Update the addressed register; drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.wave_select <= WAVE_COSINE;
      regs_q.osc_enable  <= 1'b0;
      regs_q.freq_word   <= '0;
      regs_q.offset_word <= '0;
      regs_q.amplitude   <= AMPLITUDE_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_WAVE_SELECT: regs_q.wave_select <= wave_e'(cfg_i.data[1:0]);
        CFG_OSC_ENABLE:  regs_q.osc_enable  <= cfg_i.data[0];
        CFG_FREQ_WORD:   regs_q.freq_word   <= cfg_i.data;
        CFG_OFFSET_WORD: regs_q.offset_word <= $signed(cfg_i.data);
        CFG_AMPLITUDE:   regs_q.amplitude   <= cfg_i.data[TAB_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = regs_q;

endmodule

@@ rtl/core/wom_cos_rom.sv @@
// ----------------------------------------------------------------------------
// wom_cos_rom
// Quarter-wave cosine ROM with registered read. Contents are fixed at
// elaboration from a Taylor series in Q30.
// ----------------------------------------------------------------------------
module wom_cos_rom #(
  parameter int unsigned ADDR_BITS = 10
) (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [ADDR_BITS-1:0]        addr_i,
  output logic [wom_pkg::TAB_W-1:0]   data_o
);
  import wom_pkg::*;

  localparam int unsigned TableSize = 1 << ADDR_BITS;
  localparam logic [63:0] PiQ30     = 64'd3373259426;
  localparam logic [63:0] AngleDiv  = 64'(4 * TableSize);

  typedef logic [TAB_W-1:0] rom_t [TableSize];

  // Entry i: 32767 * cos(pi * (2i+1) / (4N)), rounded, clamped to 0..32767
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    logic [63:0] v;
    for (int i = 0; i < TableSize; i++) begin
      x    = (PiQ30 * (64'(2 * i) + 64'd1)) / AngleDiv;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = longint'(term);
      term = ((term * x2) >> 30) / 64'd2;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd12;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd30;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd56;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd90;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd132;
      sum  = sum + longint'(term);
      if (sum < 0) begin
        sum = 0;
      end
      v = ((64'(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
      rom[i] = (v > 64'd32767) ? 15'd32767 : v[TAB_W-1:0];
    end
    return rom;
  endfunction

  localparam rom_t CosRom = build_rom();

  logic [TAB_W-1:0] data_q;

  // Read on demand, hold otherwise
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      data_q <= CosRom[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

@@ rtl/core/wom_mix.sv @@
// ----------------------------------------------------------------------------
// wom_mix
// Forms the oscillator sample from the held phase snapshot and ROM word,
// scales it by the amplitude and adds it to both channels with saturation.
// ----------------------------------------------------------------------------
module wom_mix (
  input  wom_pkg::cfg_t                cfg_i,
  input  logic [wom_pkg::TAB_W-1:0]    rom_data_i,
  input  wom_pkg::stage_t              stage_i,
  output wom_pkg::sample_t             left_o,
  output wom_pkg::sample_t             right_o
);
  import wom_pkg::*;

  logic signed [16:0] tab_ext;
  logic signed [16:0] wave;
  logic signed [32:0] amp_x;
  logic signed [32:0] wave_x;
  logic signed [32:0] prod;
  logic signed [32:0] rounded;
  logic signed [16:0] osc;

  function automatic sample_t sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7fff;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[SAMPLE_W-1:0];
  endfunction

  // Pick the waveform value; the ROM already holds the mirrored entry in odd quadrants
  always_comb begin
    tab_ext = $signed({2'b00, rom_data_i});
    case (cfg_i.wave_select)
      WAVE_COSINE: wave = (stage_i.quad[0] ^ stage_i.quad[1]) ? -tab_ext : tab_ext;
      WAVE_SQUARE: wave = (stage_i.quad[0] ^ stage_i.quad[1]) ? -17'sd32768 : 17'sd32768;
      WAVE_SAW:    wave = $signed({~stage_i.saw[15], ~stage_i.saw[15],
                                   stage_i.saw[14:0]});
      WAVE_SILENT: wave = '0;
      default:     wave = '0;
    endcase
  end

  // Scale by amplitude, round half up; drop the sample when disabled
  always_comb begin
    amp_x   = $signed({18'd0, cfg_i.amplitude});
    wave_x  = 33'(wave);
    prod    = amp_x * wave_x;
    rounded = prod + 33'sd16384;
    osc     = cfg_i.osc_enable ? $signed(rounded[31:15]) : 17'sd0;
  end

  // Add to both channels and clamp
  assign left_o  = sat16(18'(stage_i.left) + 18'(osc));
  assign right_o = sat16(18'(stage_i.right) + 18'(osc));

endmodule

@@ rtl/core/waveform_oscillator_mixer.sv @@
// A frame goes from the input stage to the output register once that register is free.
// Throughput: one frame per cycle unless the output stalls; single phase add, registered ROM.
// The output register lets a new frame enter while a finished one waits.
// Reset: phase zero, registers at reset values, pipeline empty; the cosine ROM is
// constant and needs no fill after reset.
// ----------------------------------------------------------------------------
// waveform_oscillator_mixer
// Phase-accumulator oscillator added into a stereo stream with a registered
// input stage (ROM read) and a registered output stage.
// ----------------------------------------------------------------------------
module waveform_oscillator_mixer #(
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned PHASE_BITS      = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wom_in_if.sink    in_i,
  wom_out_if.source out_o,
  wom_cfg_if.sink   cfg_i
);
  import wom_pkg::*;

  cfg_t                   cfg;
  logic [PHASE_BITS-1:0]  phase_q;
  logic [PHASE_BITS-1:0]  step;
  logic [63:0]            step_wide;
  logic [1:0]             quad;
  logic [TABLE_ADDR_BITS-1:0] idx;
  logic [TABLE_ADDR_BITS-1:0] rom_addr;
  logic [TAB_W-1:0]       rom_data;
  logic                   in_fire;
  logic                   s1_valid_q;
  stage_t                 s1_q;
  logic                   s2_load;
  logic                   out_valid_q;
  sample_t                left_q;
  sample_t                right_q;
  logic                   eob_q;
  sample_t                mix_left;
  sample_t                mix_right;

  wom_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Split the phase into quadrant and table index; mirror in odd quadrants
  assign quad     = phase_q[PHASE_BITS-1 -: 2];
  assign idx      = phase_q[PHASE_BITS-3 -: TABLE_ADDR_BITS];
  assign rom_addr = quad[0] ? ~idx : idx;

  // Step is the frequency word plus the sign-extended detune, modulo one turn
  assign step_wide = {32'd0, cfg.freq_word} + {{32{cfg.offset_word[31]}}, cfg.offset_word};
  assign step      = step_wide[PHASE_BITS-1:0];

  // Handshake: the input stage moves on when the output register is free
  assign s2_load    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s2_load;
  assign in_fire    = in_i.valid && in_i.ready;

  wom_cos_rom #(
    .ADDR_BITS (TABLE_ADDR_BITS)
  ) u_cos_rom (
    .clk_i   (clk_i),
    .rd_en_i (in_fire),
    .addr_i  (rom_addr),
    .data_o  (rom_data)
  );

  // Input stage control and phase advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      phase_q    <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s2_load) begin
        s1_valid_q <= 1'b0;
      end
      if (in_fire && cfg.osc_enable) begin
        phase_q <= phase_q + step;
      end
    end
  end

  // Capture the frame and its phase snapshot
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.quad  <= quad;
      s1_q.saw   <= phase_q[PHASE_BITS-1 -: SAMPLE_W];
      s1_q.left  <= in_i.left_in;
      s1_q.right <= in_i.right_in;
      s1_q.eob   <= in_i.end_of_buffer;
    end
  end

  wom_mix u_mix (
    .cfg_i      (cfg),
    .rom_data_i (rom_data),
    .stage_i    (s1_q),
    .left_o     (mix_left),
    .right_o    (mix_right)
  );

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      left_q  <= mix_left;
      right_q <= mix_right;
      eob_q   <= s1_q.eob;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.left_out          = left_q;
  assign out_o.right_out         = right_q;
  assign out_o.end_of_buffer_out = eob_q;

endmodule

@@ rtl/core/wom_checker.sv @@
// ----------------------------------------------------------------------------
// wom_checker
// Port-level checks of the oscillator mixer, bound to the top level.
// ----------------------------------------------------------------------------
`include "waveform_oscillator_mixer_defines.svh"

module wom_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input wom_pkg::sample_t out_left_i,
  input wom_pkg::sample_t out_right_i,
  input logic             out_eob_i
);

  // Hold a stalled output word
  `WOM_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `WOM_ASSERT_NEXT(a_out_data_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_left_i) && $stable(out_right_i) && $stable(out_eob_i))

  // An empty output register never blocks the input
  `WOM_ASSERT_SAME(a_ready_when_empty, clk_i, rst_ni, !out_valid_i, in_ready_i)

  // With both stages full, the input follows the output handshake
  `WOM_ASSERT_NEXT(a_full_backpressure, clk_i, rst_ni, in_valid_i && in_ready_i && out_valid_i && !out_ready_i, in_ready_i == out_ready_i)

endmodule

bind waveform_oscillator_mixer wom_checker u_wom_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_left_i  (out_o.left_out),
  .out_right_i (out_o.right_out),
  .out_eob_i   (out_o.end_of_buffer_out)
);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the oscillator mixer. Stereo frames go in on a
// valid/ready channel and every output word is compared with a local model
// of the phase accumulator, quarter-wave cosine ROM, waveform shaping,
// amplitude scaling and saturation. Register settings change only while the
// pipeline is empty.
// ----------------------------------------------------------------------------
module testbench;
  import wom_pkg::*;

  localparam int unsigned ROM_BITS     = 10;
  localparam int unsigned ROM_DEPTH    = 1 << ROM_BITS;
  localparam longint unsigned PI_Q30   = 64'd3373259426;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LIMIT_CYCLES = 500000;

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    eob;
  } mixed_frame_t;

  logic clk = 1'b0;
  logic rst_n;

  wom_in_if  in_if();
  wom_out_if out_if();
  wom_cfg_if cfg_if();

  waveform_oscillator_mixer u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Model state
  logic [TAB_W-1:0] cos_rom [ROM_DEPTH];
  logic [31:0]      osc_phase;
  cfg_t             osc_cfg;
  mixed_frame_t     expected_frames [$];

  int unsigned mismatch_count = 0;
  int unsigned frames_sent    = 0;
  int unsigned cycle_count    = 0;
  bit          tx_calm        = 1'b0;
  bit          rx_calm        = 1'b0;
  bit          hold_pending   = 1'b0;

  // Toggle the clock
  always #10 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // One quarter-wave entry: Q30 Taylor series of cos up to x^12
  function automatic logic [TAB_W-1:0] cos_entry(int unsigned i);
    longint unsigned x, x2, term, k, v;
    longint sum;
    x = (PI_Q30 * (2 * longint'(i) + 1)) / (4 * ROM_DEPTH);
    x2 = (x * x) >> 30;
    term = 64'd1 << 30;
    sum = longint'(term);
    for (k = 0; k < 6; k++) begin
      term = ((term * x2) >> 30) / ((2 * k + 1) * (2 * k + 2));
      if (k[0] == 1'b0) begin
        sum -= longint'(term);
      end else begin
        sum += longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
    if (v > 32767) begin
      v = 32767;
    end
    return v[TAB_W-1:0];
  endfunction

  // Waveform value in Q15 before amplitude scaling
  function automatic int wave_sample(logic [31:0] ph);
    logic [1:0]          quad;
    logic [ROM_BITS-1:0] idx;
    int                  saw;
    quad = ph[31:30];
    idx  = ph[29:30-ROM_BITS];
    case (osc_cfg.wave_select)
      WAVE_COSINE: begin
        case (quad)
          2'd0:    return int'(cos_rom[idx]);
          2'd1:    return -int'(cos_rom[~idx]);
          2'd2:    return -int'(cos_rom[idx]);
          default: return int'(cos_rom[~idx]);
        endcase
      end
      WAVE_SQUARE: return (quad == 2'd0 || quad == 2'd3) ? 32768 : -32768;
      WAVE_SAW: begin
        saw = ph[31:16];
        return saw - 32768;
      end
      default: return 0;
    endcase
  endfunction

  function automatic sample_t clamp16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // Mix one frame and, while the oscillator is enabled, advance the phase
  function automatic mixed_frame_t predict_mix(sample_t l, sample_t r, logic eob);
    mixed_frame_t res;
    longint       prod;
    int           osc;
    res.left  = l;
    res.right = r;
    res.eob   = eob;
    if (osc_cfg.osc_enable) begin
      prod = longint'(osc_cfg.amplitude) * longint'(wave_sample(osc_phase));
      osc = int'((prod + 16384) >>> 15);
      res.left  = clamp16(int'(l) + osc);
      res.right = clamp16(int'(r) + osc);
      osc_phase = osc_phase + osc_cfg.freq_word + osc_cfg.offset_word;
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // Gap length: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return ($urandom_range(0, 1) != 0) ? 16'sd0 : -16'sd1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Send one frame word and record what it should become
  task automatic send_frame(sample_t l, sample_t r, logic eob);
    int unsigned gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.left_in       <= l;
    in_if.right_in      <= r;
    in_if.end_of_buffer <= eob;
    do @(posedge clk); while (!in_if.ready);
    expected_frames.push_back(predict_mix(l, r, eob));
    frames_sent++;
  endtask

  // Drop valid and hold until every output word has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (expected_frames.size() != 0);
  endtask

  // Write one register; valid stays up for a following write
  task automatic write_reg(cfg_idx_t idx, cfg_dat_t value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_WAVE_SELECT: osc_cfg.wave_select = wave_e'(value[1:0]);
      CFG_OSC_ENABLE:  osc_cfg.osc_enable  = value[0];
      CFG_FREQ_WORD:   osc_cfg.freq_word   = value;
      CFG_OFFSET_WORD: osc_cfg.offset_word = value;
      CFG_AMPLITUDE:   osc_cfg.amplitude   = value[TAB_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_idle();
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_all(wave_e w, logic en, cfg_dat_t freq, cfg_dat_t off, cfg_dat_t amp);
    wait_drained();
    write_reg(CFG_WAVE_SELECT, cfg_dat_t'(w));
    write_reg(CFG_OSC_ENABLE, cfg_dat_t'(en));
    write_reg(CFG_FREQ_WORD, freq);
    write_reg(CFG_OFFSET_WORD, off);
    write_reg(CFG_AMPLITUDE, amp);
    cfg_idle();
  endtask

  // Receiver: random stalls, calm stretches and one requested long hold
  initial begin
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left  = 0;
    stall_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compare each output word with the oldest expected frame
  always @(posedge clk) begin
    mixed_frame_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("output word with no frame outstanding");
      end else begin
        want = expected_frames.pop_front();
        if (out_if.left_out !== want.left)
          report_mismatch($sformatf("left_out got %0d, expected %0d",
                                    out_if.left_out, want.left));
        if (out_if.right_out !== want.right)
          report_mismatch($sformatf("right_out got %0d, expected %0d",
                                    out_if.right_out, want.right));
        if (out_if.end_of_buffer_out !== want.eob)
          report_mismatch($sformatf("end_of_buffer_out got %b, expected %b",
                                    out_if.end_of_buffer_out, want.eob));
      end
    end
  end

  // Reset values: pass through while disabled, then mix with reset settings
  task automatic test_reset_defaults();
    send_frame(16'sd32767, -16'sd32768, 1'b1);
    send_frame(16'sd0, -16'sd1, 1'b0);
    wait_drained();
    write_reg(CFG_OSC_ENABLE, 32'd1);
    cfg_idle();
    send_frame(16'sd32767, -16'sd32768, 1'b1);
    send_frame(16'sd0, 16'sd0, 1'b0);
  endtask

  // Every waveform in turn, three frames each; the phase runs on between them
  task automatic test_waveforms();
    wave_e w;
    for (int i = 0; i < 4; i++) begin
      w = wave_e'(i);
      set_all(w, 1'b1, 32'h3000_0000, 32'h0123_4567, 32'd32767);
      send_frame(16'sd100, -16'sd100, 1'b0);
      send_frame(16'sd0, 16'sd0, 1'b1);
      send_frame(-16'sd32768, 16'sd32767, 1'b0);
    end
  endtask

  // Saturation at full and zero amplitude
  task automatic test_saturation();
    set_all(WAVE_SQUARE, 1'b1, 32'h8000_0000, 32'd0, 32'd32767);
    send_frame(16'sd32767, -16'sd32768, 1'b1);
    send_frame(16'sd32767, -16'sd32768, 1'b0);
    wait_drained();
    write_reg(CFG_AMPLITUDE, 32'd0);
    cfg_idle();
    send_frame(16'sd32767, -16'sd32768, 1'b0);
  endtask

  // Negative step wraps backward through zero
  task automatic test_negative_step();
    set_all(WAVE_SAW, 1'b1, 32'd0, 32'h8000_0000, 32'd20000);
    send_frame(16'sd1, 16'sd2, 1'b0);
    send_frame(16'sd3, 16'sd4, 1'b0);
    wait_drained();
    write_reg(CFG_FREQ_WORD, 32'hFFFF_FFFF);
    write_reg(CFG_OFFSET_WORD, 32'h7FFF_FFFF);
    cfg_idle();
    send_frame(16'sd5, 16'sd6, 1'b1);
  endtask

  // Out-of-range indexes are ignored and wide values are masked
  task automatic test_register_masking();
    wait_drained();
    write_reg(cfg_idx_t'(5), 32'hFFFF_FFFF);
    write_reg(cfg_idx_t'(6), 32'h0000_0000);
    write_reg(cfg_idx_t'(7), 32'hA5A5_A5A5);
    write_reg(CFG_AMPLITUDE, 32'hFFFF_FFFF);
    write_reg(CFG_WAVE_SELECT, 32'hFFFF_FFFE);
    write_reg(CFG_OSC_ENABLE, 32'h0000_0002);
    cfg_idle();
    send_frame(16'sd1234, -16'sd1234, 1'b0);
    wait_drained();
    write_reg(CFG_OSC_ENABLE, 32'hFFFF_FFFF);
    cfg_idle();
    send_frame(16'sd1234, -16'sd1234, 1'b1);
  endtask

  // Long receiver hold while frames keep coming, then a full drain
  task automatic test_backpressure();
    set_all(WAVE_COSINE, 1'b1, 32'h0123_4567, 32'hFFF0_0000, 32'd30000);
    hold_pending = 1'b1;
    tx_calm = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_frame(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
    end
    tx_calm = 1'b0;
    wait_drained();
  endtask

  // Random settings per phase, random frames within each
  task automatic test_random_mix();
    int unsigned target;
    int unsigned count;
    cfg_dat_t    val;
    target = frames_sent + RANDOM_ITEMS;
    while (frames_sent < target) begin
      wait_drained();
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) != 0)
        write_reg(CFG_WAVE_SELECT, $urandom_range(0, 3) | ($urandom & 32'hFFFF_FFFC));
      if ($urandom_range(0, 2) != 0)
        write_reg(CFG_OSC_ENABLE, ($urandom_range(0, 4) != 0) | ($urandom & 32'hFFFF_FFFE));
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 4))
          0:       val = 32'd0;
          1:       val = 32'hFFFF_FFFF;
          2:       val = $urandom_range(1, 32'h00FF_FFFF);
          default: val = $urandom;
        endcase
        write_reg(CFG_FREQ_WORD, val);
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 4))
          0:       val = 32'h8000_0000;
          1:       val = 32'h7FFF_FFFF;
          2:       val = 32'd0 - $urandom_range(0, 32'h00FF_FFFF);
          default: val = $urandom;
        endcase
        write_reg(CFG_OFFSET_WORD, val);
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 4))
          0:       val = 32'd0;
          1:       val = 32'd32767;
          default: val = $urandom;
        endcase
        write_reg(CFG_AMPLITUDE, val);
      end
      if ($urandom_range(0, 7) == 0)
        write_reg(cfg_idx_t'($urandom_range(5, 7)), $urandom);
      cfg_idle();
      count = $urandom_range(10, 70);
      for (int i = 0; i < count; i++) begin
        send_frame(pick_sample(), pick_sample(), ($urandom_range(0, 7) == 0));
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    // Hold every input at a known value through reset
    rst_n = 1'b0;
    in_if.valid         = 1'b0;
    in_if.left_in       = '0;
    in_if.right_in      = '0;
    in_if.end_of_buffer = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.data         = '0;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      cos_rom[i] = cos_entry(i);
    end
    osc_phase = '0;
    osc_cfg = '{wave_select: WAVE_COSINE, osc_enable: 1'b0, freq_word: 32'd0,
                offset_word: 32'sd0, amplitude: AMPLITUDE_RESET};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_waveforms();
    test_saturation();
    test_negative_step();
    test_register_masking();
    test_backpressure();
    test_random_mix();

    // Drain and let any stray word show up
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_frames.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
